[hw/rtl/salc_pkg.sv]
// ============================================================================
// salc_pkg
// Shared types, constants and helpers for the set-associative LRU cache model.
// ============================================================================
package salc_pkg;

  localparam int unsigned MAX_SET_BITS = 6;
  localparam int unsigned WAYS         = 4;
  localparam int unsigned ADDR_WIDTH   = 64;

  localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_W    = WAY_W;
  localparam int unsigned ECNT_W   = $clog2(WAYS + 1);
  localparam int unsigned TAG_W    = 64;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [63:0] ADDR_MASK =
      (ADDR_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_PROBE  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_BITS    = 2'd0,
    REG_WAYS_IN_USE = 2'd1,
    REG_OFFSET_BITS = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] address;
  } req_t;

  typedef struct packed {
    logic             access_hit;
    logic             access_evicted;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } res_t;

  typedef struct packed {
    logic latch;
    logic rd;
    logic scan_clr;
    logic scan;
    logic wr;
  } ctrl_t;

  typedef struct packed {
    logic match;
    logic last;
  } stat_t;

  typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;
  typedef logic [WAYS-1:0][AGE_W-1:0] age_row_t;
  typedef logic [WAYS-1:0]            vld_row_t;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [1:0] n);
    logic [CNT_W:0] r;
    r = {1'b0, a} + (CNT_W + 1)'(n);
    return r[CNT_W] ? {CNT_W{1'b1}} : r[CNT_W-1:0];
  endfunction

endpackage

[hw/rtl/salc_store.sv]
// ============================================================================
// salc_store
// Set storage: tag and age rows in memories, valid bits in flops.
// ============================================================================
module salc_store import salc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  input  logic [SET_W-1:0] set_i,
  input  tag_row_t         tag_row_i,
  input  age_row_t         age_row_i,
  input  vld_row_t         vld_row_i,
  output tag_row_t         tag_row_o,
  output age_row_t         age_row_o,
  output vld_row_t         vld_row_o
);

  tag_row_t tag_mem [NUM_SETS];
  age_row_t age_mem [NUM_SETS];
  vld_row_t vld_q   [NUM_SETS];

  tag_row_t tag_rd_q;
  age_row_t age_rd_q;
  vld_row_t vld_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        vld_q[i] <= '0;
      end
    end else if (ctrl_i.wr) begin
      vld_q[set_i] <= vld_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      tag_mem[set_i] <= tag_row_i;
      age_mem[set_i] <= age_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      tag_rd_q <= tag_mem[set_i];
      age_rd_q <= age_mem[set_i];
      vld_rd_q <= vld_q[set_i];
    end
  end

  // Invalid lines read as age zero.
  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      age_row_o[j] = vld_rd_q[j] ? age_rd_q[j] : '0;
    end
  end

  assign tag_row_o = tag_rd_q;
  assign vld_row_o = vld_rd_q;

endmodule

[hw/rtl/salc_scan.sv]
// ============================================================================
// salc_scan
// Shared way compare unit: one way per cycle, then the row update.
// ============================================================================
module salc_scan import salc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [ECNT_W-1:0] ways_i,
  input  tag_row_t          tag_row_i,
  input  age_row_t          age_row_i,
  input  vld_row_t          vld_row_i,
  output stat_t             stat_o,
  output logic              hit_o,
  output logic              evict_o,
  output tag_row_t          tag_row_o,
  output age_row_t          age_row_o,
  output vld_row_t          vld_row_o
);

  logic [WAY_W-1:0] way_q, way_d;
  logic             hit_q, hit_d;
  logic             have_empty_q, have_empty_d;
  logic [WAY_W-1:0] hit_way_q, hit_way_d;
  logic [WAY_W-1:0] empty_q, empty_d;
  logic [WAY_W-1:0] victim_q, victim_d;
  logic [AGE_W-1:0] best_q, best_d;

  logic [TAG_W-1:0] cur_tag;
  logic [AGE_W-1:0] cur_age;
  logic             cur_vld;
  logic [WAY_W-1:0] used_way;
  logic [AGE_W-1:0] old_age;

  always_comb begin
    cur_tag = tag_row_i[way_q];
    cur_age = age_row_i[way_q];
    cur_vld = vld_row_i[way_q];
    stat_o.match = cur_vld && (cur_tag == tag_i);
    stat_o.last  = ((ECNT_W'(way_q) + ECNT_W'(1)) == ways_i);
  end

  always_comb begin
    way_d        = way_q;
    hit_d        = hit_q;
    have_empty_d = have_empty_q;
    hit_way_d    = hit_way_q;
    empty_d      = empty_q;
    victim_d     = victim_q;
    best_d       = best_q;
    if (ctrl_i.scan_clr) begin
      way_d        = '0;
      hit_d        = 1'b0;
      have_empty_d = 1'b0;
    end else if (ctrl_i.scan) begin
      way_d = way_q + WAY_W'(1);
      if (stat_o.match) begin
        hit_d     = 1'b1;
        hit_way_d = way_q;
      end
      if (!cur_vld && !have_empty_q) begin
        have_empty_d = 1'b1;
        empty_d      = way_q;
      end
      // Oldest way wins, lowest way among equals.
      if ((way_q == '0) || (cur_age > best_q)) begin
        best_d   = cur_age;
        victim_d = way_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_q        <= '0;
      hit_q        <= 1'b0;
      have_empty_q <= 1'b0;
    end else begin
      way_q        <= way_d;
      hit_q        <= hit_d;
      have_empty_q <= have_empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_way_q <= hit_way_d;
    empty_q   <= empty_d;
    victim_q  <= victim_d;
    best_q    <= best_d;
  end

  always_comb begin
    if (hit_q) begin
      used_way = hit_way_q;
    end else if (have_empty_q) begin
      used_way = empty_q;
    end else begin
      used_way = victim_q;
    end
    old_age = hit_q ? age_row_i[hit_way_q] : AGE_OLDEST;

    age_row_o = age_row_i;
    for (int j = 0; j < WAYS; j++) begin
      if (ECNT_W'(j) < ways_i) begin
        if (WAY_W'(j) == used_way) begin
          age_row_o[j] = '0;
        end else if (vld_row_i[j] && (age_row_i[j] < old_age) &&
                     (age_row_i[j] < AGE_OLDEST)) begin
          age_row_o[j] = age_row_i[j] + AGE_W'(1);
        end
      end
    end

    tag_row_o = tag_row_i;
    if (!hit_q) begin
      tag_row_o[used_way] = tag_i;
    end
    vld_row_o           = vld_row_i;
    vld_row_o[used_way] = 1'b1;
  end

  assign hit_o   = hit_q;
  assign evict_o = !hit_q && !have_empty_q;

endmodule

[hw/rtl/salc_seq.sv]
// ============================================================================
// salc_seq
// Sequencer: read the set, scan its ways, write the row back.
// ============================================================================
module salc_seq import salc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.match || stat_i.last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o       = 1'b0;
        ctrl_o.latch = start_i;
      end
      ST_READ: begin
        ctrl_o.rd       = 1'b1;
        ctrl_o.scan_clr = 1'b1;
      end
      ST_SCAN: begin
        ctrl_o.scan = 1'b1;
      end
      ST_UPDATE: begin
        ctrl_o.wr = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/set_assoc_lru_cache_model.sv]
// ============================================================================
// set_assoc_lru_cache_model
// Set-associative cache hit/miss counter with LRU replacement.
// ============================================================================
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------
//  request   start_i & !busy_o       req_i  (command, address)
//  result    done_o, one cycle       res_o  (hit, evicted, three totals)
//  config    cfg_we_i                cfg_idx_i, cfg_data_i
//
//  A request passes through one set read, a scan in which the shared tag
//  comparator visits one way at a time until a hit or the last of the
//  ways_in_use ways, and one write, then returns to idle. The result
//  strobe rises in the cycle where busy_o falls, so the next request
//  can be taken alongside it.
//  Reset clears valid bits and totals at once; no clearing pass.
//  The receiver cannot stall results; done_o is a single-cycle pulse.
//
module set_assoc_lru_cache_model import salc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  req_t                 req_i,
  output logic                 done_o,
  output res_t                 res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // Configuration registers.
  logic [2:0]       set_bits_q;
  logic [2:0]       ways_q;
  logic [CFG_W-1:0] off_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 3'd4;
      ways_q     <= 3'd1;
      off_bits_q <= 6'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SET_BITS:    set_bits_q <= cfg_data_i[2:0];
        REG_WAYS_IN_USE: ways_q     <= cfg_data_i[2:0];
        REG_OFFSET_BITS: off_bits_q <= cfg_data_i;
        default:         set_bits_q <= set_bits_q;
      endcase
    end
  end

  // Clamp set bits and way count to what the storage holds.
  logic [6:0]        set_eff;
  logic [6:0]        split_sum;
  logic [4:0]        ways_ext;
  logic [ECNT_W-1:0] ways_eff;
  logic [63:0]       addr;
  logic [63:0]       set_full;
  logic [63:0]       set_mask;
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag_val;

  always_comb begin
    set_eff = 7'(set_bits_q);
    if (set_eff > 7'(MAX_SET_BITS)) begin
      set_eff = 7'(MAX_SET_BITS);
    end
    split_sum = set_eff + 7'(off_bits_q);

    ways_ext = 5'(ways_q);
    if (ways_ext == 5'd0) begin
      ways_ext = 5'd1;
    end else if (ways_ext > 5'(WAYS)) begin
      ways_ext = 5'(WAYS);
    end
    ways_eff = ECNT_W'(ways_ext);

    // Split the address: offset below, set index above it, tag on top.
    addr     = req_i.address & ADDR_MASK;
    set_full = addr >> off_bits_q;
    set_mask = (64'd1 << set_eff) - 64'd1;
    set_idx  = SET_W'(set_full & set_mask);
    tag_val  = (split_sum >= 7'd64) ? '0 : TAG_W'(addr >> split_sum);
  end

  // Request hold registers.
  logic [1:0]       cmd_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  ctrl_t ctrl;
  stat_t stat;

  always_ff @(posedge clk_i) begin
    if (ctrl.latch) begin
      cmd_q <= req_i.command;
      set_q <= set_idx;
      tag_q <= tag_val;
    end
  end

  salc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy_o)
  );

  tag_row_t rd_tags, wr_tags;
  age_row_t rd_ages, wr_ages;
  vld_row_t rd_vld,  wr_vld;
  logic     acc_hit, acc_evict;

  salc_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .set_i    (set_q),
    .tag_row_i(wr_tags),
    .age_row_i(wr_ages),
    .vld_row_i(wr_vld),
    .tag_row_o(rd_tags),
    .age_row_o(rd_ages),
    .vld_row_o(rd_vld)
  );

  salc_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .tag_i    (tag_q),
    .ways_i   (ways_eff),
    .tag_row_i(rd_tags),
    .age_row_i(rd_ages),
    .vld_row_i(rd_vld),
    .stat_o   (stat),
    .hit_o    (acc_hit),
    .evict_o  (acc_evict),
    .tag_row_o(wr_tags),
    .age_row_o(wr_ages),
    .vld_row_o(wr_vld)
  );

  // Running totals; a probe command leaves them untouched.
  logic [CNT_W-1:0] hits_q, hits_d;
  logic [CNT_W-1:0] misses_q, misses_d;
  logic [CNT_W-1:0] evicts_q, evicts_d;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (ctrl.wr && (cmd_q != CMD_PROBE)) begin
      if (acc_hit) begin
        hits_d = sat_add(hits_q, (cmd_q == CMD_MODIFY) ? 2'd2 : 2'd1);
      end else begin
        misses_d = sat_add(misses_q, 2'd1);
        if (acc_evict) begin
          evicts_d = sat_add(evicts_q, 2'd1);
        end
        // Modify: the store half always hits after the fill.
        if (cmd_q == CMD_MODIFY) begin
          hits_d = sat_add(hits_q, 2'd1);
        end
      end
    end
  end

  logic done_q;
  logic res_hit_q, res_evict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
      done_q   <= 1'b0;
    end else begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
      done_q   <= ctrl.wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.wr) begin
      res_hit_q   <= acc_hit;
      res_evict_q <= acc_evict;
    end
  end

  assign done_o                = done_q;
  assign res_o.access_hit      = res_hit_q;
  assign res_o.access_evicted  = res_evict_q;
  assign res_o.hit_total       = hits_q;
  assign res_o.miss_total      = misses_q;
  assign res_o.evict_total     = evicts_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.access_hit && res_o.access_evicted))
    else $error("hit and eviction reported together");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_totals_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(hits_q) || !$stable(misses_q)) |-> done_o)
    else $error("totals changed outside a result");
`endif

endmodule
